// ===== rtl/core/gsp_pkg.sv =====
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared types and constants of the graph shortest-path engine.
// ----------------------------------------------------------------------------
package gsp_pkg;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_FIND   = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [0:0] CSR_UNDIRECTED   = 1'd0;
   localparam logic [0:0] CSR_VERTEX_COUNT = 1'd1;

   localparam logic [30:0] INF_DIST = 31'h7FFF_FFFF;
   localparam int RESULT_LIMIT = 32;

   typedef enum logic [11:0] {
      ST_IDLE       = 12'b0000_0000_0001,
      ST_ADD2       = 12'b0000_0000_0010,
      ST_INIT       = 12'b0000_0000_0100,
      ST_SCAN       = 12'b0000_0000_1000,
      ST_SCAN_END   = 12'b0000_0001_0000,
      ST_E_RD       = 12'b0000_0010_0000,
      ST_E_CHK      = 12'b0000_0100_0000,
      ST_V_CHK      = 12'b0000_1000_0000,
      ST_PATH_START = 12'b0001_0000_0000,
      ST_P_CHK      = 12'b0010_0000_0000,
      ST_EM_RD      = 12'b0100_0000_0000,
      ST_EM_OUT     = 12'b1000_0000_0000
   } state_type;

endpackage

// ===== rtl/core/graph_shortest_path_engine.sv =====
// ----------------------------------------------------------------------------
// graph_shortest_path_engine
// Edge table plus Dijkstra search with a linear minimum scan over a vertex
// memory; the found path is pushed on a stack memory and replayed in order.
// ----------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+--------------------------
//  command | start, busy, req_*                      | taken when start & !busy
//  result  | rsp_valid, rsp_*                        | one-cycle strobe
//  csr     | csr_write_en, csr_index, csr_wdata      | written when enable high
//
//  Add writes one edge (in undirected mode the mirrored edge follows in ST_ADD2);
//  clear resets the edge count. Find: an init pass over the vertex memory, then
//  per visited vertex a scan of all active vertices to pick the minimum and a
//  pass over every stored edge, reading the vertex of each edge leaving it (the
//  edge and vertex memories each have a single read port); then a walk back
//  along the predecessors and one result beat per path vertex, up to RESULT_LIMIT.
//  Reset is synchronous and clears control state only; no clearing pass.
//  Results cannot be stalled; busy drops in the cycle that carries the last beat.
// ----------------------------------------------------------------------------
module graph_shortest_path_engine #(
   parameter int MAX_VERTICES = 32,
   parameter int MAX_EDGES    = 256,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [5:0]  req_source_vertex,
   input  logic [5:0]  req_dest_vertex,
   input  logic [15:0] req_edge_weight,
   output logic        rsp_valid,
   output logic [4:0]  rsp_path_vertex,
   output logic [30:0] rsp_path_length,
   output logic        rsp_path_found,
   output logic        rsp_last_result,
   input  logic        csr_write_en,
   input  logic [0:0]  csr_index,
   input  logic [5:0]  csr_wdata
);

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int NW  = $clog2(MAX_VERTICES + 1);
   localparam int XW  = 8;
   localparam int CW  = (NW > 6) ? NW : 6;
   localparam int AW  = $clog2(MAX_EDGES);
   localparam int ECW = $clog2(MAX_EDGES + 1);

   typedef struct packed {
      logic [VW-1:0]          from_v;
      logic [VW-1:0]          to_v;
      logic [WEIGHT_BITS-1:0] weight;
   } eword_type;

   typedef struct packed {
      logic          visited;
      logic          pvalid;
      logic [VW-1:0] pred;
      logic [30:0]   cost;
   } vword_type;

   // memories
   eword_type     edge_mem [MAX_EDGES];
   vword_type     vert_mem [MAX_VERTICES];
   logic [VW-1:0] stack_mem [MAX_VERTICES];

   logic          em_we;
   logic [AW-1:0] em_wa, em_ra;
   eword_type     em_wd, em_q;
   logic          vm_we;
   logic [VW-1:0] vm_wa, vm_ra;
   vword_type     vm_wd, vm_q;
   logic          sm_we;
   logic [VW-1:0] sm_wa, sm_ra, sm_wd, sm_q;

   always_ff @(posedge clock) begin
      if (em_we) begin
         edge_mem[em_wa] <= em_wd;
      end
      em_q <= edge_mem[em_ra];
   end

   always_ff @(posedge clock) begin
      if (vm_we) begin
         vert_mem[vm_wa] <= vm_wd;
      end
      vm_q <= vert_mem[vm_ra];
   end

   always_ff @(posedge clock) begin
      if (sm_we) begin
         stack_mem[sm_wa] <= sm_wd;
      end
      sm_q <= stack_mem[sm_ra];
   end

   // registers
   gsp_pkg::state_type     state_ff, state_in;
   logic [ECW-1:0]         ec_ff, ec_in;
   logic                   und_ff, und_in;
   logic [5:0]             vc_ff, vc_in;
   logic [VW-1:0]          s_ff, s_in, d_ff, d_in;
   logic [NW-1:0]          vi_ff, vi_in;
   logic                   pend_ff, pend_in;
   logic [VW-1:0]          pidx_ff, pidx_in;
   logic [30:0]            best_ff, best_in;
   vword_type              bword_ff, bword_in;
   logic [VW-1:0]          cur_ff, cur_in;
   logic                   got_ff, got_in;
   logic [ECW-1:0]         e_ff, e_in;
   logic [VW-1:0]          eto_ff, eto_in;
   logic [WEIGHT_BITS-1:0] ew_ff, ew_in;
   logic [VW-1:0]          pc_ff, pc_in;
   logic [NW-1:0]          depth_ff, depth_in;
   logic [30:0]            len_ff, len_in;
   logic [CW-1:0]          i_ff, i_in;
   eword_type              mirror_ff, mirror_in;
   logic                   rv_ff, rv_in;
   logic [4:0]             rpv_ff, rpv_in;
   logic [30:0]            rlen_ff, rlen_in;
   logic                   rfound_ff, rfound_in;
   logic                   rlast_ff, rlast_in;

   logic [NW-1:0] n_act;
   logic [CW-1:0] emit;
   logic [31:0]   nd;
   logic          src_ok, dst_ok;
   logic [ECW:0]  need;

   always_comb begin
      n_act = (XW'(vc_ff) > XW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vc_ff);
      emit  = (CW'(depth_ff) > CW'(gsp_pkg::RESULT_LIMIT)) ?
              CW'(gsp_pkg::RESULT_LIMIT) : CW'(depth_ff);
      nd    = {1'b0, best_ff} + 32'(ew_ff);
      src_ok = XW'(req_source_vertex) < XW'(n_act);
      dst_ok = XW'(req_dest_vertex) < XW'(n_act);
      need   = (ECW + 1)'(ec_ff) + (und_ff ? (ECW + 1)'(2) : (ECW + 1)'(1));
   end

   always_comb begin
      state_in  = state_ff;
      ec_in     = ec_ff;
      und_in    = und_ff;
      vc_in     = vc_ff;
      s_in      = s_ff;
      d_in      = d_ff;
      vi_in     = vi_ff;
      pend_in   = 1'b0;
      pidx_in   = pidx_ff;
      best_in   = best_ff;
      bword_in  = bword_ff;
      cur_in    = cur_ff;
      got_in    = got_ff;
      e_in      = e_ff;
      eto_in    = eto_ff;
      ew_in     = ew_ff;
      pc_in     = pc_ff;
      depth_in  = depth_ff;
      len_in    = len_ff;
      i_in      = i_ff;
      mirror_in = mirror_ff;
      rv_in     = 1'b0;
      rpv_in    = rpv_ff;
      rlen_in   = rlen_ff;
      rfound_in = rfound_ff;
      rlast_in  = rlast_ff;

      em_we = 1'b0;
      em_wa = ec_ff[AW-1:0];
      em_wd = mirror_ff;
      em_ra = e_ff[AW-1:0];
      vm_we = 1'b0;
      vm_wa = vi_ff[VW-1:0];
      vm_wd = bword_ff;
      vm_ra = vi_ff[VW-1:0];
      sm_we = 1'b0;
      sm_wa = depth_ff[VW-1:0];
      sm_wd = pc_ff;
      sm_ra = VW'(CW'(depth_ff) - CW'(1) - i_ff);

      if (csr_write_en) begin
         case (csr_index)
            gsp_pkg::CSR_UNDIRECTED:   und_in = csr_wdata[0];
            gsp_pkg::CSR_VERTEX_COUNT: vc_in  = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         gsp_pkg::ST_IDLE: begin
            if (start) begin
               case (req_command)
                  gsp_pkg::CMD_ADD: begin
                     if (src_ok && dst_ok && need <= (ECW + 1)'(MAX_EDGES)) begin
                        em_we        = 1'b1;
                        em_wd.from_v = VW'(req_source_vertex);
                        em_wd.to_v   = VW'(req_dest_vertex);
                        em_wd.weight = req_edge_weight[WEIGHT_BITS-1:0];
                        ec_in        = ec_ff + ECW'(1);
                        if (und_ff) begin
                           mirror_in.from_v = VW'(req_dest_vertex);
                           mirror_in.to_v   = VW'(req_source_vertex);
                           mirror_in.weight = req_edge_weight[WEIGHT_BITS-1:0];
                           state_in         = gsp_pkg::ST_ADD2;
                        end
                     end
                  end
                  gsp_pkg::CMD_FIND: begin
                     if (!src_ok || !dst_ok) begin
                        rv_in     = 1'b1;
                        rpv_in    = '0;
                        rlen_in   = gsp_pkg::INF_DIST;
                        rfound_in = 1'b0;
                        rlast_in  = 1'b1;
                     end else begin
                        s_in     = VW'(req_source_vertex);
                        d_in     = VW'(req_dest_vertex);
                        vi_in    = '0;
                        state_in = gsp_pkg::ST_INIT;
                     end
                  end
                  gsp_pkg::CMD_CLEAR: ec_in = '0;
                  default: ;
               endcase
            end
         end

         gsp_pkg::ST_ADD2: begin
            em_we    = 1'b1;
            ec_in    = ec_ff + ECW'(1);
            state_in = gsp_pkg::ST_IDLE;
         end

         gsp_pkg::ST_INIT: begin
            vm_we         = 1'b1;
            vm_wd.visited = 1'b0;
            vm_wd.pvalid  = 1'b0;
            vm_wd.pred    = '0;
            vm_wd.cost    = (vi_ff[VW-1:0] == s_ff) ? '0 : gsp_pkg::INF_DIST;
            vi_in         = vi_ff + NW'(1);
            if (NW'(vi_ff + NW'(1)) == n_act) begin
               vi_in    = '0;
               best_in  = gsp_pkg::INF_DIST;
               got_in   = 1'b0;
               state_in = gsp_pkg::ST_SCAN;
            end
         end

         gsp_pkg::ST_SCAN: begin
            // issue one vertex read a cycle, compare the beat of the last one
            if (vi_ff < n_act) begin
               pend_in = 1'b1;
               pidx_in = vi_ff[VW-1:0];
               vi_in   = vi_ff + NW'(1);
            end
            if (pend_ff && !vm_q.visited && vm_q.cost < best_ff) begin
               best_in  = vm_q.cost;
               bword_in = vm_q;
               cur_in   = pidx_ff;
               got_in   = 1'b1;
            end
            if (!(vi_ff < n_act) && !pend_ff) begin
               state_in = gsp_pkg::ST_SCAN_END;
            end
         end

         gsp_pkg::ST_SCAN_END: begin
            if (!got_ff) begin
               state_in = gsp_pkg::ST_PATH_START;
            end else begin
               vm_we         = 1'b1;
               vm_wa         = cur_ff;
               vm_wd.visited = 1'b1;
               e_in          = '0;
               state_in = (cur_ff == d_ff) ? gsp_pkg::ST_PATH_START : gsp_pkg::ST_E_RD;
            end
         end

         gsp_pkg::ST_E_RD: begin
            if (e_ff < ec_ff) begin
               state_in = gsp_pkg::ST_E_CHK;
            end else begin
               vi_in    = '0;
               best_in  = gsp_pkg::INF_DIST;
               got_in   = 1'b0;
               state_in = gsp_pkg::ST_SCAN;
            end
         end

         gsp_pkg::ST_E_CHK: begin
            if (em_q.from_v == cur_ff && XW'(em_q.to_v) < XW'(n_act)) begin
               vm_ra    = em_q.to_v;
               eto_in   = em_q.to_v;
               ew_in    = em_q.weight;
               state_in = gsp_pkg::ST_V_CHK;
            end else begin
               e_in     = e_ff + ECW'(1);
               state_in = gsp_pkg::ST_E_RD;
            end
         end

         gsp_pkg::ST_V_CHK: begin
            if (!vm_q.visited && nd < {1'b0, vm_q.cost}) begin
               vm_we         = 1'b1;
               vm_wa         = eto_ff;
               vm_wd.visited = 1'b0;
               vm_wd.pvalid  = 1'b1;
               vm_wd.pred    = cur_ff;
               vm_wd.cost    = nd[30:0];
            end
            e_in     = e_ff + ECW'(1);
            state_in = gsp_pkg::ST_E_RD;
         end

         gsp_pkg::ST_PATH_START: begin
            vm_ra    = d_ff;
            pc_in    = d_ff;
            depth_in = '0;
            state_in = gsp_pkg::ST_P_CHK;
         end

         gsp_pkg::ST_P_CHK: begin
            if (depth_ff == '0 && vm_q.cost == gsp_pkg::INF_DIST) begin
               rv_in     = 1'b1;
               rpv_in    = '0;
               rlen_in   = gsp_pkg::INF_DIST;
               rfound_in = 1'b0;
               rlast_in  = 1'b1;
               state_in  = gsp_pkg::ST_IDLE;
            end else begin
               if (depth_ff == '0) begin
                  len_in = vm_q.cost;
               end
               sm_we    = 1'b1;
               depth_in = depth_ff + NW'(1);
               if (!vm_q.pvalid || NW'(depth_ff + NW'(1)) == n_act) begin
                  i_in     = '0;
                  state_in = gsp_pkg::ST_EM_RD;
               end else begin
                  // walk back to the predecessor
                  pc_in = vm_q.pred;
                  vm_ra = vm_q.pred;
               end
            end
         end

         gsp_pkg::ST_EM_RD: begin
            state_in = gsp_pkg::ST_EM_OUT;
         end

         gsp_pkg::ST_EM_OUT: begin
            rv_in     = 1'b1;
            rpv_in    = 5'(sm_q);
            rlen_in   = len_ff;
            rfound_in = 1'b1;
            rlast_in  = (CW'(i_ff + CW'(1)) == emit);
            i_in      = i_ff + CW'(1);
            state_in  = (CW'(i_ff + CW'(1)) == emit) ? gsp_pkg::ST_IDLE : gsp_pkg::ST_EM_RD;
         end

         default: state_in = gsp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gsp_pkg::ST_IDLE;
         ec_ff    <= '0;
         und_ff   <= 1'b0;
         vc_ff    <= 6'd32;
         pend_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ec_ff    <= ec_in;
         und_ff   <= und_in;
         vc_ff    <= vc_in;
         pend_ff  <= pend_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff      <= s_in;
      d_ff      <= d_in;
      vi_ff     <= vi_in;
      pidx_ff   <= pidx_in;
      best_ff   <= best_in;
      bword_ff  <= bword_in;
      cur_ff    <= cur_in;
      got_ff    <= got_in;
      e_ff      <= e_in;
      eto_ff    <= eto_in;
      ew_ff     <= ew_in;
      pc_ff     <= pc_in;
      depth_ff  <= depth_in;
      len_ff    <= len_in;
      i_ff      <= i_in;
      mirror_ff <= mirror_in;
      rpv_ff    <= rpv_in;
      rlen_ff   <= rlen_in;
      rfound_ff <= rfound_in;
      rlast_ff  <= rlast_in;
   end

   assign busy            = (state_ff != gsp_pkg::ST_IDLE);
   assign rsp_valid       = rv_ff;
   assign rsp_path_vertex = rpv_ff;
   assign rsp_path_length = rlen_ff;
   assign rsp_path_found  = rfound_ff;
   assign rsp_last_result = rlast_ff;

   a_edge_count_bound: assert property (@(posedge clock) disable iff (reset)
      ec_ff <= ECW'(MAX_EDGES))
      else $error("edge count beyond table size");

   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gsp_pkg::ST_EM_OUT) |-> (i_ff < emit))
      else $error("emit index past path depth");

   a_visit_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gsp_pkg::ST_SCAN_END && got_ff) |-> (XW'(cur_ff) < XW'(n_act)))
      else $error("selected vertex outside active range");

   a_found_has_length: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rfound_ff) |-> (rlen_ff != gsp_pkg::INF_DIST))
      else $error("found path carries infinite length");

endmodule
